FILE: hdl/size_class_block_pool_allocator_unit_assert.svh
`ifndef SIZE_CLASS_BLOCK_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define SIZE_CLASS_BLOCK_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCBPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCBPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: hdl/scbpa_pkg.sv
package scbpa_pkg;

  localparam int SpanBits   = 28;
  localparam int AlignBytes = 16;
  localparam int MaxBlocks  = 256;
  localparam int PoolSlots  = 4;

  localparam int PoolW  = 2;
  localparam int IdxW   = 8;
  localparam int CntW   = 9;
  localparam int BytesW = 21;
  localparam int SizeW  = 22;
  localparam int AddrW  = 31;
  localparam int ProdW  = 31;
  localparam int RemW   = 30;
  localparam int IdxTopW = 4;

  // Low bit of a register index selects the field of a pool.
  localparam logic CfgSelBytes = 1'b0;
  localparam logic CfgSelCount = 1'b1;

  typedef enum logic [3:0] {
    ST_POOLED      = 4'd0,
    ST_ZERO_HEAP   = 4'd1,
    ST_EXHAUSTED   = 4'd2,
    ST_OVERSIZE    = 4'd3,
    ST_FREED       = 4'd4,
    ST_FOREIGN     = 4'd5,
    ST_NULL        = 4'd6,
    ST_DOUBLE_FREE = 4'd7,
    ST_MISALIGNED  = 4'd8
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ASCAN, S_ASEL, S_AIDX, S_ASET,
    S_FMUL, S_FCMP, S_FDIV, S_FCHK, S_FUSE, S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    AR_NOP, AR_MUL, AR_DIV_LOAD, AR_DIV_STEP
  } arith_op_e;

  typedef struct packed {
    logic                 func;
    logic [31:0]          request_bytes;
    logic [AddrW-1:0]     free_address;
  } in_req_t;

  typedef struct packed {
    status_e              status;
    logic [AddrW-1:0]     block_address;
    logic [PoolW-1:0]     pool_number;
    logic [CntW-1:0]      blocks_free;
  } out_rsp_t;

  typedef struct packed {
    arith_op_e            op;
    logic [SizeW-1:0]     size;
    logic [CntW-1:0]      mult;
    logic [RemW-1:0]      offset;
  } arith_req_t;

  typedef struct packed {
    logic [ProdW-1:0]     prod;
    logic [RemW-1:0]      rem;
    logic [IdxW-1:0]      quo;
  } arith_rsp_t;

  function automatic logic [SizeW-1:0] round_size(input logic [BytesW-1:0] bytes);
    logic [SizeW-1:0] sum;
    sum = {1'b0, bytes} + SizeW'(AlignBytes - 1);
    return sum & ~SizeW'(AlignBytes - 1);
  endfunction

  function automatic logic [AddrW-1:0] pool_base(input logic [PoolW-1:0] p);
    return AddrW'({1'b0, p} + 3'd1) << SpanBits;
  endfunction

endpackage

FILE: hdl/scbpa_ram.sv
module scbpa_ram #(
  parameter int Depth = 1024,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/scbpa_arith.sv
module scbpa_arith (
  input  logic                  clk_i,
  input  scbpa_pkg::arith_req_t req_i,
  output scbpa_pkg::arith_rsp_t rsp_o
);
  import scbpa_pkg::*;

  logic [ProdW-1:0]   prod_q;
  logic [RemW-1:0]    rem_q;
  logic [SizeW+6:0]   dsh_q;
  logic [IdxW-1:0]    quo_q;
  logic               fits;

  // One restoring division step: the divisor walks down one bit per cycle.
  assign fits = rem_q >= RemW'(dsh_q);

  always_ff @(posedge clk_i) begin
    unique case (req_i.op)
      AR_MUL: begin
        prod_q <= ProdW'(req_i.size) * ProdW'(req_i.mult);
      end
      AR_DIV_LOAD: begin
        rem_q <= req_i.offset;
        dsh_q <= {req_i.size, 7'd0};
        quo_q <= '0;
      end
      AR_DIV_STEP: begin
        if (fits) begin
          rem_q <= rem_q - RemW'(dsh_q);
        end
        quo_q <= {quo_q[IdxW-2:0], fits};
        dsh_q <= dsh_q >> 1;
      end
      AR_NOP: begin
      end
    endcase
  end

  assign rsp_o = '{prod: prod_q, rem: rem_q, quo: quo_q};

endmodule

FILE: hdl/size_class_block_pool_allocator_unit.sv
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+----------------------------
// in        | input     | in_valid_i / in_stall_o | in_req_i (func, size, addr)
// out       | output    | out_valid_o/out_stall_i | out_rsp_o (status, address)
// cfg       | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An allocate request scans the size of every pool in turn, then pops the stack,
// looks up the block index and multiplies out the address.
// A free request does a multiply and a range compare per pool until one matches,
// then runs the serial divider, the remainder check and the in-use check.
// There is no clearing pass after reset; the block takes requests right away.
// The finished result sits in an output register, so a stalled output only holds
// the next result back in its last state; the input stalls while a request is worked on.
module size_class_block_pool_allocator_unit #(
  parameter int NUM_POOLS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  scbpa_pkg::in_req_t   in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output scbpa_pkg::out_rsp_t  out_rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [3:0]           cfg_index_i,
  input  logic [scbpa_pkg::BytesW-1:0] cfg_data_i
);
  import scbpa_pkg::*;

  localparam int StkDepth = NUM_POOLS * MaxBlocks;
  localparam int StkAw    = $clog2(StkDepth);
  localparam int Rows     = NUM_POOLS * (MaxBlocks / 16);
  localparam int UseAw    = $clog2(Rows);

  // Pool configuration and free stack bookkeeping. The low-water mark tracks the
  // smallest stack depth since the pool was set up: stack slots below it were never
  // rewritten and still hold their own index.
  logic [SizeW-1:0] size_q  [PoolSlots];
  logic [CntW-1:0]  count_q [PoolSlots];
  logic [CntW-1:0]  depth_q [PoolSlots];
  logic [CntW-1:0]  lw_q    [PoolSlots];
  logic [Rows-1:0]  row_vld_q;

  state_e           state_q, state_d;
  logic [31:0]      req_q;
  logic [AddrW-1:0] faddr_q;
  logic [PoolW-1:0] p_q;
  logic             best_v_q;
  logic [PoolW-1:0] best_q;
  logic [SizeW-1:0] best_size_q;
  logic [IdxW-1:0]  idx_q;
  logic             written_q;
  logic             rowv_q;
  logic [2:0]       step_q;
  out_rsp_t         res_q, res_d;
  out_rsp_t         out_q;
  logic             out_valid_q;

  arith_req_t       ar_req;
  arith_rsp_t       ar_rsp;

  logic             stk_we, stk_re, use_we, use_re;
  logic [StkAw-1:0] stk_waddr, stk_raddr;
  logic [IdxW-1:0]  stk_wdata, stk_rdata;
  logic [UseAw-1:0] use_waddr, use_raddr;
  logic [15:0]      use_wdata, use_rdata;

  logic             accept, scan_last, fit, better, in_region, pop_en, push_en, emit;
  logic             cfg_wr;
  logic [PoolW-1:0] cfg_pool;
  logic [CntW-1:0]  cfg_cnt_sat, cfg_new_cnt;
  logic [SizeW-1:0] cur_size;
  logic [CntW-1:0]  cur_cnt;
  logic [AddrW-1:0] cur_base;
  logic [31:0]      limit;
  logic [CntW-1:0]  best_depth, pop_depth;
  logic [IdxW-1:0]  pick_idx;
  logic [15:0]      row_eff;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign scan_last  = (p_q == PoolW'(NUM_POOLS - 1));
  assign cur_size   = size_q[p_q];
  assign cur_cnt    = count_q[p_q];
  assign cur_base   = pool_base(p_q);
  assign fit        = (cur_cnt != '0) && ({10'd0, cur_size} >= req_q);
  assign better     = fit && (!best_v_q || (cur_size < best_size_q));
  assign limit      = {1'b0, cur_base} + {1'b0, ar_rsp.prod};
  assign in_region  = (cur_cnt != '0) && (cur_size != '0) && (faddr_q >= cur_base) &&
                      ({1'b0, faddr_q} < limit);
  assign best_depth = depth_q[best_q];
  assign pop_depth  = best_depth - 9'd1;
  // A stack slot that was never rewritten since setup holds its own index.
  assign pick_idx   = written_q ? stk_rdata : idx_q;
  // An in-use row that was never written since setup reads as all clear.
  assign row_eff    = rowv_q ? use_rdata : 16'd0;

  assign cfg_wr      = cfg_valid_i && cfg_ready_o && !cfg_index_i[3];
  assign cfg_pool    = cfg_index_i[2:1];
  assign cfg_cnt_sat = (cfg_data_i[CntW-1:0] > CntW'(MaxBlocks)) ? CntW'(MaxBlocks)
                                                                 : cfg_data_i[CntW-1:0];
  assign cfg_new_cnt = (cfg_index_i[0] == CfgSelCount) ? cfg_cnt_sat : count_q[cfg_pool];

  always_comb begin
    state_d   = state_q;
    ar_req    = '{op: AR_NOP, size: '0, mult: '0, offset: '0};
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_re    = 1'b0;
    stk_raddr = '0;
    use_we    = 1'b0;
    use_waddr = '0;
    use_wdata = '0;
    use_re    = 1'b0;
    use_raddr = '0;
    pop_en    = 1'b0;
    push_en   = 1'b0;
    emit      = 1'b0;
    res_d     = '{status: ST_POOLED, block_address: '0, pool_number: '0, blocks_free: '0};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_req_i.func) begin
            if (in_req_i.free_address == '0) begin
              res_d.status = ST_NULL;
              state_d      = S_EMIT;
            end else begin
              state_d = S_FMUL;
            end
          end else begin
            if (in_req_i.request_bytes == '0) begin
              res_d.status = ST_ZERO_HEAP;
              state_d      = S_EMIT;
            end else begin
              state_d = S_ASCAN;
            end
          end
        end
      end
      S_ASCAN: begin
        if (scan_last) begin
          state_d = S_ASEL;
        end
      end
      S_ASEL: begin
        if (!best_v_q) begin
          res_d.status = ST_OVERSIZE;
          state_d      = S_EMIT;
        end else if (best_depth == '0) begin
          res_d.status      = ST_EXHAUSTED;
          res_d.pool_number = best_q;
          state_d           = S_EMIT;
        end else begin
          stk_re    = 1'b1;
          stk_raddr = StkAw'({best_q, pop_depth[IdxW-1:0]});
          pop_en    = 1'b1;
          state_d   = S_AIDX;
        end
      end
      S_AIDX: begin
        use_re    = 1'b1;
        use_raddr = UseAw'({best_q, pick_idx[IdxW-1:IdxTopW]});
        ar_req    = '{op: AR_MUL, size: best_size_q, mult: {1'b0, pick_idx}, offset: '0};
        state_d   = S_ASET;
      end
      S_ASET: begin
        use_we              = 1'b1;
        use_waddr           = UseAw'({best_q, idx_q[IdxW-1:IdxTopW]});
        use_wdata           = row_eff | (16'd1 << idx_q[IdxTopW-1:0]);
        res_d.status        = ST_POOLED;
        res_d.block_address = pool_base(best_q) + ar_rsp.prod;
        res_d.pool_number   = best_q;
        res_d.blocks_free   = best_depth;
        state_d             = S_EMIT;
      end
      S_FMUL: begin
        ar_req  = '{op: AR_MUL, size: cur_size, mult: cur_cnt, offset: '0};
        state_d = S_FCMP;
      end
      S_FCMP: begin
        if (in_region) begin
          ar_req  = '{op: AR_DIV_LOAD, size: cur_size, mult: '0,
                      offset: RemW'(faddr_q - cur_base)};
          state_d = S_FDIV;
        end else if (scan_last) begin
          res_d.status = ST_FOREIGN;
          state_d      = S_EMIT;
        end else begin
          state_d = S_FMUL;
        end
      end
      S_FDIV: begin
        ar_req.op = AR_DIV_STEP;
        if (step_q == 3'd7) begin
          state_d = S_FCHK;
        end
      end
      S_FCHK: begin
        if (ar_rsp.rem != '0) begin
          res_d.status      = ST_MISALIGNED;
          res_d.pool_number = p_q;
          res_d.blocks_free = depth_q[p_q];
          state_d           = S_EMIT;
        end else begin
          use_re    = 1'b1;
          use_raddr = UseAw'({p_q, ar_rsp.quo[IdxW-1:IdxTopW]});
          state_d   = S_FUSE;
        end
      end
      S_FUSE: begin
        res_d.pool_number = p_q;
        res_d.blocks_free = depth_q[p_q];
        if (!row_eff[ar_rsp.quo[IdxTopW-1:0]]) begin
          res_d.status = ST_DOUBLE_FREE;
        end else begin
          res_d.status = ST_FREED;
          use_we       = 1'b1;
          use_waddr    = UseAw'({p_q, ar_rsp.quo[IdxW-1:IdxTopW]});
          use_wdata    = row_eff & ~(16'd1 << ar_rsp.quo[IdxTopW-1:0]);
          if (depth_q[p_q] < cur_cnt) begin
            stk_we            = 1'b1;
            stk_waddr         = StkAw'({p_q, depth_q[p_q][IdxW-1:0]});
            stk_wdata         = ar_rsp.quo;
            push_en           = 1'b1;
            res_d.blocks_free = depth_q[p_q] + 9'd1;
          end
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Pool configuration, stack depths and in-use row valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PoolSlots; i++) begin
        size_q[i]  <= SizeW'(AlignBytes);
        count_q[i] <= '0;
        depth_q[i] <= '0;
        lw_q[i]    <= '0;
      end
      row_vld_q <= '0;
    end else begin
      if (cfg_wr) begin
        if (cfg_index_i[0] == CfgSelCount) begin
          count_q[cfg_pool] <= cfg_cnt_sat;
        end else begin
          size_q[cfg_pool] <= round_size(cfg_data_i);
        end
        // Writing either register of a pool sets that pool up from scratch.
        if ({1'b0, cfg_pool} < 3'(NUM_POOLS)) begin
          depth_q[cfg_pool] <= cfg_new_cnt;
          lw_q[cfg_pool]    <= cfg_new_cnt;
          for (int r = 0; r < MaxBlocks / 16; r++) begin
            row_vld_q[UseAw'({cfg_pool, IdxTopW'(r)})] <= 1'b0;
          end
        end
      end
      if (pop_en) begin
        depth_q[best_q] <= pop_depth;
        if (pop_depth < lw_q[best_q]) begin
          lw_q[best_q] <= pop_depth;
        end
      end
      if (push_en) begin
        depth_q[p_q] <= depth_q[p_q] + 9'd1;
      end
      if (use_we) begin
        row_vld_q[use_waddr] <= 1'b1;
      end
    end
  end

  // Request operands, scan state, divider step count, popped index and result registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= in_req_i.request_bytes;
      faddr_q  <= in_req_i.free_address;
      p_q      <= '0;
      best_v_q <= 1'b0;
    end
    if (state_q == S_ASCAN) begin
      if (better) begin
        best_v_q    <= 1'b1;
        best_q      <= p_q;
        best_size_q <= cur_size;
      end
      p_q <= p_q + 2'd1;
    end
    if ((state_q == S_FCMP) && !in_region) begin
      p_q <= p_q + 2'd1;
    end
    if ((state_q == S_FCMP) && in_region) begin
      step_q <= '0;
    end
    if (state_q == S_FDIV) begin
      step_q <= step_q + 3'd1;
    end
    if (pop_en) begin
      idx_q     <= pop_depth[IdxW-1:0];
      written_q <= (pop_depth >= lw_q[best_q]);
    end
    if (state_q == S_AIDX) begin
      idx_q <= pick_idx;
    end
    if (use_re) begin
      rowv_q <= row_vld_q[use_raddr];
    end
    if (state_d == S_EMIT && state_q != S_EMIT) begin
      res_q <= res_d;
    end
    if (emit) begin
      out_q <= res_q;
    end
  end

  scbpa_arith u_arith (
    .clk_i (clk_i),
    .req_i (ar_req),
    .rsp_o (ar_rsp)
  );

  scbpa_ram #(
    .Depth (StkDepth),
    .Width (IdxW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  scbpa_ram #(
    .Depth (Rows),
    .Width (16)
  ) u_use_ram (
    .clk_i   (clk_i),
    .we_i    (use_we),
    .waddr_i (use_waddr),
    .wdata_i (use_wdata),
    .re_i    (use_re),
    .raddr_i (use_raddr),
    .rdata_o (use_rdata)
  );

endmodule

FILE: hdl/scbpa_port_checker.sv
`include "size_class_block_pool_allocator_unit_assert.svh"

module scbpa_port_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input scbpa_pkg::in_req_t   in_req_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input scbpa_pkg::out_rsp_t  out_rsp_o,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic [3:0]           cfg_index_i,
  input logic [scbpa_pkg::BytesW-1:0] cfg_data_i
);
  import scbpa_pkg::*;

  `SCBPA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o))

  `SCBPA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  `SCBPA_ASSERT_IMP(a_addr_only_pooled, clk_i, rst_ni, out_valid_o && (out_rsp_o.status != ST_POOLED), out_rsp_o.block_address == '0)

  `SCBPA_ASSERT_IMP(a_no_pool_fields, clk_i, rst_ni, out_valid_o && ((out_rsp_o.status == ST_ZERO_HEAP) || (out_rsp_o.status == ST_OVERSIZE) || (out_rsp_o.status == ST_FOREIGN) || (out_rsp_o.status == ST_NULL)), (out_rsp_o.pool_number == '0) && (out_rsp_o.blocks_free == '0))

endmodule

bind size_class_block_pool_allocator_unit scbpa_port_checker u_port_checker (.*);

FILE: tb/scbpa_checker.sv
`timescale 1ns / 1ps

module scbpa_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  scbpa_pkg::in_req_t   in_req_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  scbpa_pkg::out_rsp_t  out_rsp_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [3:0]           cfg_index_i,
  input  logic [scbpa_pkg::BytesW-1:0] cfg_data_i,
  output int                   errors_o,
  output int                   pending_o
);
  import scbpa_pkg::*;

  logic [20:0] bytes_q [4];
  logic [8:0]  count_q [4];
  logic [7:0]  stack_q [4][256];
  int unsigned depth_q [4];
  bit          used_q  [4][256];
  out_rsp_t    expected_q [$];

  assign pending_o = expected_q.size();

  function automatic longint unsigned rounded(int p);
    return (longint'(bytes_q[p]) + 15) / 16 * 16;
  endfunction

  function automatic int unsigned blocks(int p);
    return (count_q[p] > 256) ? 256 : count_q[p];
  endfunction

  function automatic void reload(int p);
    for (int i = 0; i < 256; i++) begin
      stack_q[p][i] = i[7:0];
      used_q[p][i] = 0;
    end
    depth_q[p] = blocks(p);
  endfunction

  function automatic out_rsp_t mk(status_e s, longint unsigned a, int p, int unsigned n);
    out_rsp_t r;
    r.status = s;
    r.block_address = a[30:0];
    r.pool_number = p[1:0];
    r.blocks_free = n[8:0];
    return r;
  endfunction

  function automatic out_rsp_t allocate(longint unsigned req);
    int best;
    longint unsigned best_sz, s;
    int unsigned idx;
    best = -1;
    best_sz = 0;
    if (req == 0) return mk(ST_ZERO_HEAP, 0, 0, 0);
    for (int p = 0; p < 4; p++) begin
      s = rounded(p);
      if (blocks(p) == 0 || req > s) continue;
      if (best < 0 || s < best_sz) begin
        best = p;
        best_sz = s;
      end
    end
    if (best < 0) return mk(ST_OVERSIZE, 0, 0, 0);
    if (depth_q[best] == 0) return mk(ST_EXHAUSTED, 0, best, 0);
    depth_q[best]--;
    idx = stack_q[best][depth_q[best]];
    used_q[best][idx] = 1;
    return mk(ST_POOLED, (longint'(best + 1) << 28) + idx * best_sz, best, depth_q[best]);
  endfunction

  function automatic out_rsp_t release_block(longint unsigned addr);
    longint unsigned s, base, off, idx;
    int unsigned n;
    if (addr == 0) return mk(ST_NULL, 0, 0, 0);
    for (int p = 0; p < 4; p++) begin
      s = rounded(p);
      n = blocks(p);
      base = longint'(p + 1) << 28;
      if (n == 0 || s == 0) continue;
      if (addr < base || addr >= base + s * n) continue;
      off = addr - base;
      if (off % s != 0) return mk(ST_MISALIGNED, 0, p, depth_q[p]);
      idx = off / s;
      if (idx >= 256 || !used_q[p][idx]) return mk(ST_DOUBLE_FREE, 0, p, depth_q[p]);
      used_q[p][idx] = 0;
      if (depth_q[p] < n) begin
        stack_q[p][depth_q[p]] = idx[7:0];
        depth_q[p]++;
      end
      return mk(ST_FREED, 0, p, depth_q[p]);
    end
    return mk(ST_FOREIGN, 0, 0, 0);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_rsp_t exp_rsp;
    int p;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      errors_o <= 0;
      expected_q.delete();
      for (int i = 0; i < 4; i++) begin
        bytes_q[i] = 21'd16;
        count_q[i] = 9'd0;
        reload(i);
      end
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < 8) begin
        p = cfg_index_i >> 1;
        if (cfg_index_i[0] == CfgSelCount) count_q[p] = cfg_data_i[8:0];
        else bytes_q[p] = cfg_data_i;
        reload(p);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no request pending: status %0d", out_rsp_i.status);
          errs++;
        end else begin
          exp_rsp = expected_q.pop_front();
          if (out_rsp_i.status !== exp_rsp.status) begin
            $error("status expected %0d actual %0d", exp_rsp.status, out_rsp_i.status);
            errs++;
          end
          if (out_rsp_i.block_address !== exp_rsp.block_address) begin
            $error("block_address expected %h actual %h", exp_rsp.block_address,
                   out_rsp_i.block_address);
            errs++;
          end
          if (out_rsp_i.pool_number !== exp_rsp.pool_number) begin
            $error("pool_number expected %0d actual %0d", exp_rsp.pool_number,
                   out_rsp_i.pool_number);
            errs++;
          end
          if (out_rsp_i.blocks_free !== exp_rsp.blocks_free) begin
            $error("blocks_free expected %0d actual %0d", exp_rsp.blocks_free,
                   out_rsp_i.blocks_free);
            errs++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_req_i.func) begin
          expected_q.insert(expected_q.size(), release_block(in_req_i.free_address));
        end else begin
          expected_q.insert(expected_q.size(), allocate(in_req_i.request_bytes));
        end
      end
      errors_o <= errors_o + errs;
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

// Top of the pool allocator testbench. It configures the four pools through the
// register port, sends allocate and free requests with random gaps and drives
// random output stall. Prediction and result checking live in scbpa_checker.
module tb;
  import scbpa_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_req_t     in_req;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_rsp_t    out_rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [BytesW-1:0] cfg_data;
  int          errors;
  int          pending;
  int          cycles = 0;
  bit          quiet;        // when set, neither side inserts idle cycles
  bit          stall_on;

  // Addresses handed out and not yet freed, so that frees can hit real blocks.
  logic [30:0] live_q [$];

  size_class_block_pool_allocator_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_rsp_o(out_rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  scbpa_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_rsp_i(out_rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The watchdog allows far more time than the slowest correct run needs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The output stall is drawn at random with a probability of 29 percent unless in a quiet stretch.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 29);
  end

  // One register write; the checker reloads its pool model on the same edge.
  // Valid stays high so that writes follow back to back; the caller drops it.
  task automatic write_reg(input int idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx[3:0];
    cfg_data  <= value[BytesW-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic setup_pools(input int unsigned sz[4], input int unsigned cnt[4]);
    for (int p = 0; p < 4; p++) begin
      write_reg(2 * p, sz[p]);
      write_reg(2 * p + 1, cnt[p]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Stops sending, waits until every result is back, then lets the free path's
  // worst latency pass.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Sends one request after an optional random gap; holds it until accepted.
  // Valid stays high afterwards until the next request or a drain takes over.
  task automatic send(input logic func, input logic [31:0] bytes, input logic [30:0] addr);
    if (!quiet) begin
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_req.func <= func;
    in_req.request_bytes <= bytes;
    in_req.free_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Remembers pooled addresses by watching the result stream.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_rsp.status == ST_POOLED)
      live_q.insert(live_q.size(), out_rsp.block_address);
  end

  task automatic alloc_req(input logic [31:0] bytes);
    send(1'b0, bytes, 31'($urandom()));
  endtask

  task automatic free_req(input logic [30:0] addr);
    send(1'b1, $urandom(), addr);
  endtask

  // One random request, biased toward sizes near the pool sizes and real frees.
  task automatic random_req(input int unsigned sz[4]);
    int unsigned r;
    int unsigned k;
    logic [30:0] a;
    r = $urandom_range(99);
    if (r < 45) begin
      k = $urandom_range(3);
      alloc_req((sz[k] + 15) / 16 * 16 - $urandom_range(16));
    end else if (r < 52) begin
      alloc_req($urandom());
    end else if (r < 80 && live_q.size() != 0) begin
      k = $urandom_range(live_q.size() - 1);
      a = live_q[k];
      live_q.delete(k);
      free_req(a);
    end else if (r < 88) begin
      k = $urandom_range(3);
      a = 31'(((k + 1) << 28) + $urandom_range(4095));
      free_req(a);
    end else if (r < 93) begin
      free_req(31'({$urandom()} % 32'h50000000));
    end else begin
      free_req(31'($urandom()));
    end
  endtask

  initial begin
    int unsigned sz[4];
    int unsigned cnt[4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: right after reset every pool is disabled.
    alloc_req(32'd0);
    alloc_req(32'd1);
    free_req(31'd0);
    free_req(31'h10000000);
    drain();

    // Small pools, one with the largest count, to hit exhaustion and ties.
    sz = '{16, 16, 100, 1048576};
    cnt = '{2, 256, 3, 511};
    setup_pools(sz, cnt);
    alloc_req(32'hFFFFFFFF);
    alloc_req(32'd16);
    alloc_req(32'd16);
    alloc_req(32'd1048576);
    alloc_req(32'd1048577);
    alloc_req(32'd97);
    alloc_req(32'd101);
    drain();
    free_req(31'h10000010);
    free_req(31'h10000010);
    free_req(31'h10000008);
    free_req(31'h7FFFFFFF);
    free_req(31'h40000000);
    free_req(31'h50000000);
    free_req(31'h30000000);
    drain();
    live_q.delete();

    // Random phases over several pool settings; one of them runs without idling.
    for (int ph = 0; ph < 5; ph++) begin
      for (int p = 0; p < 4; p++) begin
        case ($urandom_range(3))
          0: sz[p] = $urandom_range(16, 64);
          1: sz[p] = $urandom_range(1, 2048);
          2: sz[p] = (ph == 4) ? 0 : 2097151;
          default: sz[p] = $urandom_range(1, 2097151);
        endcase
        cnt[p] = (ph == 3) ? 0 : $urandom_range(0, 24);
      end
      if (ph == 3) cnt[1] = 511;
      setup_pools(sz, cnt);
      live_q.delete();
      quiet = (ph == 2);
      for (int n = 0; n < 95; n++) random_req(sz);
      quiet = 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
